// ----- rtl/mep_pkg.sv -----
// Shared constants, types and helper functions for the Mandelbrot escape-time pixel block.
`timescale 1ns / 1ps

package mep_pkg;

    // Fixed-point format: signed Q4.28 in 32 bits
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int STEP_W    = 31;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 16;
    localparam int COLOR_W   = 8;

    // Scaled index product, sum before saturation
    localparam int PROD_W = IDX_W + STEP_W;
    localparam int SUM_W  = PROD_W + 1;
    // Floored square (unsigned Q7.F, never negative) and floored cross term 2*zx*zy
    localparam int SQ_W    = 2 * Q_W - 1 - FRAC_BITS;
    localparam int CROSS_W = 2 * Q_W + 1 - FRAC_BITS;
    localparam int MAG_W   = SQ_W + 1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] ESCAPE_BOUND = MAG_W'(4) << FRAC_BITS;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = CFG_IDX_W'(4);

    localparam logic signed [Q_W-1:0] RST_REAL_ORIGIN = -Q_W'(671088640);
    localparam logic signed [Q_W-1:0] RST_IMAG_ORIGIN = -Q_W'(536870912);
    localparam logic [STEP_W-1:0]     RST_REAL_STEP   = STEP_W'(262144);
    localparam logic [STEP_W-1:0]     RST_IMAG_STEP   = STEP_W'(262144);
    localparam logic [CNT_W-1:0]      RST_ITER_LIMIT  = CNT_W'(200);

    localparam int PAL_IDX_W = 5;
    localparam logic [PAL_IDX_W-1:0] GREY_ENTRY = PAL_IDX_W'(16);

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // Controller -> datapath
    typedef struct packed {
        logic capture;  // latch pixel indices
        logic scale;    // index * step products
        logic place;    // form c, clear z and count
        logic square;   // zx^2, zy^2, 2*zx*zy
        logic step;     // z update, count increment
        logic emit;     // load result register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic finished;
    } t_dp_status;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(Q_MAX);
        lo = SUM_W'(Q_MIN);
        if (v > hi) begin
            return Q_MAX;
        end else if (v < lo) begin
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic t_rgb palette_rgb(input logic [PAL_IDX_W-1:0] idx);
        t_rgb c;
        case (idx)
            5'd0: begin
                c = '{8'd66, 8'd30, 8'd15};
            end
            5'd1: begin
                c = '{8'd25, 8'd7, 8'd26};
            end
            5'd2: begin
                c = '{8'd9, 8'd1, 8'd47};
            end
            5'd3: begin
                c = '{8'd4, 8'd4, 8'd73};
            end
            5'd4: begin
                c = '{8'd0, 8'd7, 8'd100};
            end
            5'd5: begin
                c = '{8'd12, 8'd44, 8'd138};
            end
            5'd6: begin
                c = '{8'd24, 8'd82, 8'd177};
            end
            5'd7: begin
                c = '{8'd57, 8'd125, 8'd209};
            end
            5'd8: begin
                c = '{8'd134, 8'd181, 8'd229};
            end
            5'd9: begin
                c = '{8'd211, 8'd236, 8'd248};
            end
            5'd10: begin
                c = '{8'd241, 8'd233, 8'd191};
            end
            5'd11: begin
                c = '{8'd248, 8'd201, 8'd95};
            end
            5'd12: begin
                c = '{8'd255, 8'd170, 8'd0};
            end
            5'd13: begin
                c = '{8'd204, 8'd128, 8'd0};
            end
            5'd14: begin
                c = '{8'd153, 8'd87, 8'd0};
            end
            5'd15: begin
                c = '{8'd106, 8'd52, 8'd3};
            end
            default: begin
                c = '{8'd16, 8'd16, 8'd16};
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/mandelbrot_escape_pixel.sv -----
// Top level of the Mandelbrot escape-time pixel block.
// One pixel at a time: a beat on the input channel carries a column and row, which map to
// c = origin + index * step in signed Q4.28 (saturated; the imaginary part snaps to zero when
// 2*|c_im| < imag_step). The block then runs z = z^2 + c from zero until |z|^2 >= 4 or the
// iteration limit is reached, and returns the count with an RGB color (dark grey at the limit,
// else gradient entry count mod 16). Each iteration runs the square state for the three
// 32x32 multiplies (zx^2, zy^2, 2*zx*zy), then the step state for the add, saturate and
// escape compare. A finished pixel is held until the previous result has been taken. A
// finished result sits in an output register, so the next pixel is accepted while it waits.
// The user must write registers through the config port (always ready) only while no pixel
// is in flight; the block itself does not enforce this. Index 0..4 = real_origin, imag_origin,
// real_step, imag_step, iteration_limit, other indexes are ignored.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mep_pkg::IDX_W-1:0]         i_column_index,
    input  logic [mep_pkg::IDX_W-1:0]         i_row_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mep_pkg::CNT_W-1:0]         o_iteration_count,
    output logic [mep_pkg::COLOR_W-1:0]       o_red,
    output logic [mep_pkg::COLOR_W-1:0]       o_green,
    output logic [mep_pkg::COLOR_W-1:0]       o_blue,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import mep_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_rgb       rgb;

    assign o_cfg_ready = 1'b1;

    mep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    mep_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_column_index    (i_column_index),
        .i_row_index       (i_row_index),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_iteration_count (o_iteration_count),
        .o_rgb             (rgb)
    );

    assign o_red   = rgb.red;
    assign o_green = rgb.green;
    assign o_blue  = rgb.blue;

endmodule

// ----- rtl/mep_ctrl.sv -----
// Sequencing state machine for the escape-time pixel: setup, iterate, result handoff.
`timescale 1ns / 1ps

module mep_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mep_pkg::t_dp_cmd    o_cmd,
    input  mep_pkg::t_dp_status i_status
);
    import mep_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCALE  = 5'b00010,
        S_PLACE  = 5'b00100,
        S_SQUARE = 5'b01000,
        S_STEP   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    // result register can take a new beat if empty or being drained now
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_STEP;
            end
            S_STEP: begin
                if (i_status.finished) begin
                    if (out_free) begin
                        o_cmd.emit  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SQUARE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/mep_datapath.sv -----
// Datapath: config registers, point mapping, z iteration, escape test and color lookup.
`timescale 1ns / 1ps

module mep_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mep_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mep_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic [mep_pkg::IDX_W-1:0]           i_column_index,
    input  logic [mep_pkg::IDX_W-1:0]           i_row_index,
    input  mep_pkg::t_dp_cmd                    i_cmd,
    output mep_pkg::t_dp_status                 o_status,
    output logic [mep_pkg::CNT_W-1:0]           o_iteration_count,
    output mep_pkg::t_rgb                       o_rgb
);
    import mep_pkg::*;

    // configuration
    logic signed [Q_W-1:0]    r_real_origin, r_imag_origin;
    logic [STEP_W-1:0]        r_real_step, r_imag_step;
    logic [CNT_W-1:0]         r_limit;

    // per-pixel working registers
    logic [IDX_W-1:0]         r_col, r_row;
    logic [PROD_W-1:0]        r_prod_re, r_prod_im;
    logic signed [Q_W-1:0]    r_cx, r_cy, r_zx, r_zy;
    logic [SQ_W-1:0]          r_sq_x, r_sq_y;
    logic signed [CROSS_W-1:0] r_cross;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_out_count;
    t_rgb                     r_out_rgb;

    logic signed [SUM_W-1:0]  sum_cre, sum_cim;
    logic signed [Q_W-1:0]    cx_sat, cy_sat;
    logic [Q_W-1:0]           cy_abs;
    logic [Q_W:0]             cy_mag2;
    logic                     cy_snap;

    logic signed [Q_W:0]      zx_dbl;
    logic signed [2*Q_W-1:0]  p_xx, p_yy;
    logic signed [2*Q_W:0]    p_xy;

    logic signed [CROSS_W-1:0] zsum_re, zsum_im;
    logic [MAG_W-1:0]         mag;
    logic                     at_limit;
    logic [PAL_IDX_W-1:0]     pal_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_origin <= RST_REAL_ORIGIN;
            r_imag_origin <= RST_IMAG_ORIGIN;
            r_real_step   <= RST_REAL_STEP;
            r_imag_step   <= RST_IMAG_STEP;
            r_limit       <= RST_ITER_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REAL_ORIGIN: begin
                    r_real_origin <= i_cfg_data[Q_W-1:0];
                end
                REG_IMAG_ORIGIN: begin
                    r_imag_origin <= i_cfg_data[Q_W-1:0];
                end
                REG_REAL_STEP: begin
                    r_real_step <= i_cfg_data[STEP_W-1:0];
                end
                REG_IMAG_STEP: begin
                    r_imag_step <= i_cfg_data[STEP_W-1:0];
                end
                REG_ITER_LIMIT: begin
                    r_limit <= i_cfg_data[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // c = origin + index * step, saturated to Q4.F
    assign sum_cre = SUM_W'(r_real_origin) + $signed({1'b0, r_prod_re});
    assign sum_cim = SUM_W'(r_imag_origin) + $signed({1'b0, r_prod_im});
    assign cx_sat  = sat_q(sum_cre);
    assign cy_sat  = sat_q(sum_cim);
    // imaginary part snaps to zero when 2*|cy| < imag_step
    assign cy_abs  = cy_sat[Q_W-1] ? (~cy_sat + 1'b1) : cy_sat;
    assign cy_mag2 = {cy_abs, 1'b0};
    assign cy_snap = cy_mag2 < {2'b00, r_imag_step};

    // products are floored by an arithmetic right shift
    assign zx_dbl = {r_zx, 1'b0};
    assign p_xx   = r_zx * r_zx;
    assign p_yy   = r_zy * r_zy;
    assign p_xy   = zx_dbl * r_zy;

    assign zsum_re = $signed({2'b00, r_sq_x}) - $signed({2'b00, r_sq_y})
                     + CROSS_W'(r_cx);
    assign zsum_im = r_cross + CROSS_W'(r_cy);

    assign mag      = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign at_limit = (r_count == r_limit);
    assign o_status.finished = at_limit || (mag >= ESCAPE_BOUND);
    assign pal_idx  = at_limit ? GREY_ENTRY : {1'b0, r_count[3:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_column_index;
            r_row <= i_row_index;
        end
        if (i_cmd.scale) begin
            r_prod_re <= PROD_W'(r_col) * PROD_W'(r_real_step);
            r_prod_im <= PROD_W'(r_row) * PROD_W'(r_imag_step);
        end
        if (i_cmd.place) begin
            r_cx    <= cx_sat;
            r_cy    <= cy_snap ? '0 : cy_sat;
            r_zx    <= '0;
            r_zy    <= '0;
            r_count <= '0;
        end
        if (i_cmd.square) begin
            r_sq_x  <= p_xx[2*Q_W-2:FRAC_BITS];
            r_sq_y  <= p_yy[2*Q_W-2:FRAC_BITS];
            r_cross <= p_xy[2*Q_W:FRAC_BITS];
        end
        if (i_cmd.step) begin
            r_zx    <= sat_q(SUM_W'(zsum_re));
            r_zy    <= sat_q(SUM_W'(zsum_im));
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_count <= r_count;
            r_out_rgb   <= palette_rgb(pal_idx);
        end
    end

    assign o_iteration_count = r_out_count;
    assign o_rgb             = r_out_rgb;

endmodule

// ----- rtl/mep_checker.sv -----
// Port-level checks for the escape-time pixel block, bound to the top level.
`timescale 1ns / 1ps

module mep_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [mep_pkg::CNT_W-1:0]         o_iteration_count,
    input logic [mep_pkg::COLOR_W-1:0]       o_red,
    input logic [mep_pkg::COLOR_W-1:0]       o_green,
    input logic [mep_pkg::COLOR_W-1:0]       o_blue
);
    import mep_pkg::*;

    // no result left over from before reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one pixel in flight: an accepted beat closes the input until done
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a pixel is in flight");

    // a zero count only comes from a zero limit, which is shown as grey
    a_zero_count_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_iteration_count == '0)) |->
            (o_red == 8'd16) && (o_green == 8'd16) && (o_blue == 8'd16))
        else $error("zero count without grey color");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_iteration_count) && $stable(o_red)
             && $stable(o_green) && $stable(o_blue)))
        else $error("stalled result beat changed");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);
